### hdl/xrb_pkg.sv
`default_nettype none

package xrb_pkg;

  localparam int WORD_W = 64;
  localparam int HALF_W = 32;
  localparam int OP_W   = 2;
  localparam int CASE_W = 3;

  // splitmix64 constants
  localparam logic [WORD_W-1:0] GAMMA_STEP = 64'h9E3779B97F4A7C15;
  localparam logic [WORD_W-1:0] MIX_MUL_A  = 64'hBF58476D1CE4E5B9;
  localparam logic [WORD_W-1:0] MIX_MUL_B  = 64'h94D049BB133111EB;
  localparam int MIX_SHR_0 = 30;
  localparam int MIX_SHR_1 = 27;
  localparam int MIX_SHR_2 = 31;

  // xoshiro256** constants
  localparam int SCR_MUL5_SHL = 2;
  localparam int SCR_ROT      = 7;
  localparam int SCR_MUL9_SHL = 3;
  localparam int XS_SHL       = 17;
  localparam int XS_ROT       = 45;

  localparam logic [WORD_W-1:0] SMALL_CAP = 64'd16;

  // size draw cases, taken from the low bits of one raw draw
  localparam logic [CASE_W-1:0] CASE_ZERO     = 3'd0;
  localparam logic [CASE_W-1:0] CASE_MAX      = 3'd1;
  localparam logic [CASE_W-1:0] CASE_SMALL_LO = 3'd2;
  localparam logic [CASE_W-1:0] CASE_SMALL_HI = 3'd4;

  typedef enum logic [OP_W-1:0] {
    OP_RAW     = 2'd0,
    OP_BOUNDED = 2'd1,
    OP_SIZE    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_ARG,
    RES_RND,
    RES_REM
  } res_sel_t;

  typedef enum logic [1:0] {
    BND_ARG,
    BND_SMALL,
    BND_MAXP1
  } bound_sel_t;

  // 64x64 low product built from three 32x32 partial products
  typedef enum logic [1:0] {
    MUL_LL,
    MUL_LH,
    MUL_HL
  } mul_phase_t;

  typedef struct packed {
    logic       seed_init;
    logic       seed_add;
    logic       mul_en;
    mul_phase_t mul_phase;
    logic       mul_const_b;
    logic       seed_xor;
    logic       seed_store;
    logic       load_arg;
    logic       raw_step;
    logic       raw_finish;
    logic       load_bound;
    bound_sel_t bound_sel;
    logic       div_start;
    logic       div_of_rnd;
    logic       thr_load;
    logic       out_load;
    res_sel_t   res_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic              bound_le1;
    logic              rnd_ge_thr;
    logic [CASE_W-1:0] rnd_case;
    logic              arg_max;
    logic              div_done;
  } dp_stat_t;

  function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] x,
                                               input int unsigned n);
    return (x << n) | (x >> (WORD_W - n));
  endfunction

endpackage

`default_nettype wire

### hdl/xrb_divider.sv
`default_nettype none

// Restoring remainder unit, one quotient bit per cycle.
module xrb_divider (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [xrb_pkg::WORD_W-1:0]  dividend,
  input  wire logic [xrb_pkg::WORD_W-1:0]  divisor,
  output logic                             done,
  output logic [xrb_pkg::WORD_W-1:0]       remainder
);

  localparam int CNT_W = $clog2(xrb_pkg::WORD_W);

  logic                        busy;
  logic [CNT_W-1:0]            cnt;
  logic [xrb_pkg::WORD_W-1:0]  dvd;
  logic [xrb_pkg::WORD_W-1:0]  dvs;
  logic [xrb_pkg::WORD_W:0]    shifted;
  logic [xrb_pkg::WORD_W:0]    trial;

  assign shifted = {remainder, dvd[xrb_pkg::WORD_W-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(xrb_pkg::WORD_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      dvd       <= dividend;
      dvs       <= divisor;
    end else if (busy) begin
      dvd <= dvd << 1;
      if (!trial[xrb_pkg::WORD_W]) begin
        remainder <= trial[xrb_pkg::WORD_W-1:0];
      end else begin
        remainder <= shifted[xrb_pkg::WORD_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

### hdl/xrb_datapath.sv
`default_nettype none

module xrb_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [xrb_pkg::WORD_W-1:0]  s_axis_tdata,
  input  wire logic                        seed_we,
  input  wire logic [xrb_pkg::WORD_W-1:0]  seed_wdata,
  input  wire xrb_pkg::dp_cmd_t            cmd,
  output xrb_pkg::dp_stat_t                stat,
  output logic [xrb_pkg::WORD_W-1:0]       value
);

  localparam int W = xrb_pkg::WORD_W;
  localparam int H = xrb_pkg::HALF_W;

  logic [W-1:0] seed;
  logic [W-1:0] ctr;
  logic [W-1:0] z;
  logic [W-1:0] acc;
  logic [W-1:0] gen_words [4];
  logic [W-1:0] mul5;
  logic [W-1:0] rnd;
  logic [W-1:0] thr;
  logic [W-1:0] arg;
  logic [W-1:0] bound;

  logic [W-1:0] ctr_sum;
  logic [W-1:0] mix_k;
  logic [H-1:0] mul_x;
  logic [H-1:0] mul_y;
  logic [W-1:0] prod;
  logic [W-1:0] cap;
  logic [W-1:0] rot7;
  logic [W-1:0] xs_t;
  logic [W-1:0] n0, n1, n2, n3;
  logic [W-1:0] div_dvd;
  logic         div_done;
  logic [W-1:0] div_rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (seed_we) begin
      seed <= seed_wdata;
    end
  end

  assign ctr_sum = ctr + xrb_pkg::GAMMA_STEP;

  // one shared 32x32 multiplier for the splitmix products
  assign mix_k = cmd.mul_const_b ? xrb_pkg::MIX_MUL_B : xrb_pkg::MIX_MUL_A;
  assign mul_x = (cmd.mul_phase == xrb_pkg::MUL_HL) ? z[W-1:H] : z[H-1:0];
  assign mul_y = (cmd.mul_phase == xrb_pkg::MUL_LH) ? mix_k[W-1:H] : mix_k[H-1:0];
  assign prod  = {{H{1'b0}}, mul_x} * {{H{1'b0}}, mul_y};

  // xoshiro256** state transition
  assign xs_t = gen_words[1] << xrb_pkg::XS_SHL;
  assign n2   = gen_words[2] ^ gen_words[0];
  assign n3   = gen_words[3] ^ gen_words[1];
  assign n1   = gen_words[1] ^ n2;
  assign n0   = gen_words[0] ^ n3;
  assign rot7 = xrb_pkg::rotl64(mul5, xrb_pkg::SCR_ROT);

  assign cap     = (arg < xrb_pkg::SMALL_CAP) ? arg : xrb_pkg::SMALL_CAP;
  assign div_dvd = cmd.div_of_rnd ? rnd : (W'(0) - bound);

  xrb_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_dvd),
    .divisor   (bound),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.seed_init) begin
      ctr <= seed;
    end
    if (cmd.seed_add) begin
      ctr <= ctr_sum;
      z   <= ctr_sum ^ (ctr_sum >> xrb_pkg::MIX_SHR_0);
    end else if (cmd.seed_xor) begin
      z <= acc ^ (acc >> xrb_pkg::MIX_SHR_1);
    end
    if (cmd.mul_en) begin
      case (cmd.mul_phase)
        xrb_pkg::MUL_LL: acc <= prod;
        default:         acc[W-1:H] <= acc[W-1:H] + prod[H-1:0];
      endcase
    end
    if (cmd.seed_store) begin
      gen_words[0] <= gen_words[1];
      gen_words[1] <= gen_words[2];
      gen_words[2] <= gen_words[3];
      gen_words[3] <= acc ^ (acc >> xrb_pkg::MIX_SHR_2);
    end else if (cmd.raw_step) begin
      gen_words[0] <= n0;
      gen_words[1] <= n1;
      gen_words[2] <= n2 ^ xs_t;
      gen_words[3] <= xrb_pkg::rotl64(n3, xrb_pkg::XS_ROT);
      mul5         <= gen_words[1] + (gen_words[1] << xrb_pkg::SCR_MUL5_SHL);
    end
    if (cmd.raw_finish) begin
      rnd <= rot7 + (rot7 << xrb_pkg::SCR_MUL9_SHL);
    end
    if (cmd.load_arg) begin
      arg <= s_axis_tdata;
    end
    if (cmd.load_bound) begin
      case (cmd.bound_sel)
        xrb_pkg::BND_SMALL: bound <= cap + W'(1);
        xrb_pkg::BND_MAXP1: bound <= arg + W'(1);
        default:            bound <= arg;
      endcase
    end
    if (cmd.thr_load) begin
      thr <= div_rem;
    end
    if (cmd.out_load) begin
      case (cmd.res_sel)
        xrb_pkg::RES_ARG: value <= arg;
        xrb_pkg::RES_RND: value <= rnd;
        xrb_pkg::RES_REM: value <= div_rem;
        default:          value <= '0;
      endcase
    end
  end

  assign stat.bound_le1  = (bound[W-1:1] == '0);
  assign stat.rnd_ge_thr = (rnd >= thr);
  assign stat.rnd_case   = rnd[xrb_pkg::CASE_W-1:0];
  assign stat.arg_max    = &arg;
  assign stat.div_done   = div_done;

endmodule

`default_nettype wire

### hdl/xrb_control.sv
`default_nettype none

module xrb_control (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  input  wire logic [xrb_pkg::OP_W-1:0] s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  input  wire logic                     seed_we,
  input  wire xrb_pkg::dp_stat_t        stat,
  output xrb_pkg::dp_cmd_t              cmd
);

  typedef enum logic [4:0] {
    S_SEED_INIT,
    S_SEED_ADD,
    S_SEED_MA0,
    S_SEED_MA1,
    S_SEED_MA2,
    S_SEED_XOR,
    S_SEED_MB0,
    S_SEED_MB1,
    S_SEED_MB2,
    S_SEED_STORE,
    S_IDLE,
    S_RAW_A,
    S_RAW_B,
    S_CLASSIFY,
    S_BND_SETUP,
    S_BND_TEST,
    S_THR_WAIT,
    S_CHECK,
    S_REM_WAIT,
    S_FIN
  } state_t;

  // what to do with a finished raw draw
  typedef enum logic [1:0] {
    G_OUT,
    G_SIZE,
    G_CHECK
  } goal_t;

  state_t              state;
  goal_t               goal;
  xrb_pkg::res_sel_t   res;
  xrb_pkg::bound_sel_t bsel;
  logic [1:0]          word_cnt;
  logic                out_free;

  assign s_axis_tready = (state == S_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    cmd             = '0;
    cmd.mul_phase   = xrb_pkg::MUL_LL;
    cmd.bound_sel   = bsel;
    cmd.res_sel     = res;
    unique case (state)
      S_SEED_INIT:  cmd.seed_init = 1'b1;
      S_SEED_ADD:   cmd.seed_add  = 1'b1;
      S_SEED_MA0:   cmd.mul_en    = 1'b1;
      S_SEED_MA1: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_phase = xrb_pkg::MUL_LH;
      end
      S_SEED_MA2: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_phase = xrb_pkg::MUL_HL;
      end
      S_SEED_XOR:   cmd.seed_xor  = 1'b1;
      S_SEED_MB0: begin
        cmd.mul_en      = 1'b1;
        cmd.mul_const_b = 1'b1;
      end
      S_SEED_MB1: begin
        cmd.mul_en      = 1'b1;
        cmd.mul_const_b = 1'b1;
        cmd.mul_phase   = xrb_pkg::MUL_LH;
      end
      S_SEED_MB2: begin
        cmd.mul_en      = 1'b1;
        cmd.mul_const_b = 1'b1;
        cmd.mul_phase   = xrb_pkg::MUL_HL;
      end
      S_SEED_STORE: cmd.seed_store = 1'b1;
      S_IDLE:       cmd.load_arg   = s_axis_tvalid;
      S_RAW_A:      cmd.raw_step   = 1'b1;
      S_RAW_B:      cmd.raw_finish = 1'b1;
      S_BND_SETUP:  cmd.load_bound = 1'b1;
      // threshold = (2^64 - bound) mod bound
      S_BND_TEST:   cmd.div_start  = !stat.bound_le1;
      S_THR_WAIT:   cmd.thr_load   = stat.div_done;
      S_CHECK: begin
        cmd.div_start  = stat.rnd_ge_thr;
        cmd.div_of_rnd = 1'b1;
      end
      S_FIN:        cmd.out_load   = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_SEED_INIT;
      goal          <= G_OUT;
      res           <= xrb_pkg::RES_ZERO;
      bsel          <= xrb_pkg::BND_ARG;
      word_cnt      <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // in the finish state a taken beat is replaced by the next one
      if (m_axis_tvalid && m_axis_tready && (seed_we || state != S_FIN)) begin
        m_axis_tvalid <= 1'b0;
      end
      if (seed_we) begin
        state    <= S_SEED_INIT;
        word_cnt <= '0;
      end else begin
        unique case (state)
          S_SEED_INIT: state <= S_SEED_ADD;
          S_SEED_ADD:  state <= S_SEED_MA0;
          S_SEED_MA0:  state <= S_SEED_MA1;
          S_SEED_MA1:  state <= S_SEED_MA2;
          S_SEED_MA2:  state <= S_SEED_XOR;
          S_SEED_XOR:  state <= S_SEED_MB0;
          S_SEED_MB0:  state <= S_SEED_MB1;
          S_SEED_MB1:  state <= S_SEED_MB2;
          S_SEED_MB2:  state <= S_SEED_STORE;
          S_SEED_STORE: begin
            word_cnt <= word_cnt + 2'd1;
            state    <= (word_cnt == 2'd3) ? S_IDLE : S_SEED_ADD;
          end
          S_IDLE: begin
            if (s_axis_tvalid) begin
              unique case (xrb_pkg::op_t'(s_axis_tuser))
                xrb_pkg::OP_RAW: begin
                  goal  <= G_OUT;
                  state <= S_RAW_A;
                end
                xrb_pkg::OP_BOUNDED: begin
                  bsel  <= xrb_pkg::BND_ARG;
                  state <= S_BND_SETUP;
                end
                xrb_pkg::OP_SIZE: begin
                  goal  <= G_SIZE;
                  state <= S_RAW_A;
                end
                xrb_pkg::OP_NONE: begin
                  res   <= xrb_pkg::RES_ZERO;
                  state <= S_FIN;
                end
              endcase
            end
          end
          S_RAW_A: state <= S_RAW_B;
          S_RAW_B: begin
            case (goal)
              G_SIZE:  state <= S_CLASSIFY;
              G_CHECK: state <= S_CHECK;
              default: begin
                res   <= xrb_pkg::RES_RND;
                state <= S_FIN;
              end
            endcase
          end
          S_CLASSIFY: begin
            case (stat.rnd_case) inside
              xrb_pkg::CASE_ZERO: begin
                res   <= xrb_pkg::RES_ZERO;
                state <= S_FIN;
              end
              xrb_pkg::CASE_MAX: begin
                res   <= xrb_pkg::RES_ARG;
                state <= S_FIN;
              end
              [xrb_pkg::CASE_SMALL_LO:xrb_pkg::CASE_SMALL_HI]: begin
                bsel  <= xrb_pkg::BND_SMALL;
                state <= S_BND_SETUP;
              end
              default: begin
                // full range: an all-ones maximum takes a plain raw draw
                if (stat.arg_max) begin
                  goal  <= G_OUT;
                  state <= S_RAW_A;
                end else begin
                  bsel  <= xrb_pkg::BND_MAXP1;
                  state <= S_BND_SETUP;
                end
              end
            endcase
          end
          S_BND_SETUP: state <= S_BND_TEST;
          S_BND_TEST: begin
            if (stat.bound_le1) begin
              res   <= xrb_pkg::RES_ZERO;
              state <= S_FIN;
            end else begin
              state <= S_THR_WAIT;
            end
          end
          S_THR_WAIT: begin
            if (stat.div_done) begin
              goal  <= G_CHECK;
              state <= S_RAW_A;
            end
          end
          S_CHECK: state <= stat.rnd_ge_thr ? S_REM_WAIT : S_RAW_A;
          S_REM_WAIT: begin
            if (stat.div_done) begin
              res   <= xrb_pkg::RES_REM;
              state <= S_FIN;
            end
          end
          S_FIN: begin
            if (out_free) begin
              m_axis_tvalid <= 1'b1;
              state         <= S_IDLE;
            end
          end
          default: state <= S_SEED_INIT;
        endcase
      end
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second beat taken while a request is in work");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == S_FIN))
    else $error("result raised outside the finish state");

  a_check_after_draw: assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK |-> $past(state == S_RAW_B))
    else $error("threshold compare without a fresh draw");

endmodule

`default_nettype wire

### hdl/xoshiro256ss_bounded_random.sv
`default_nettype none

// xoshiro256** random source with splitmix64 seeding. One request beat is taken at a
// time: tuser carries the kind (raw, bounded below the argument, size up to the argument,
// or the unused opcode, which gives zero) and tdata the argument; each request gives
// exactly one result beat. A raw draw and a bound of 0 or 1 need no division. Any other
// bounded draw runs two remainder passes on the shared bit-serial divider (threshold, then
// the final modulo), and every rejected draw is replaced by a fresh draw before the modulo.
// A size request picks its case from one raw draw: zero, the maximum, a raw draw on an
// all-ones maximum, zero for a bound of 1, else the bounded path on a capped or full bound.
// A result not yet taken holds the next request in its finish state, so tready stays low
// from then until the waiting beat goes. After reset and after every seed write the block
// expands the seed into the four generator words, with tready low.
module xoshiro256ss_bounded_random (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [xrb_pkg::WORD_W-1:0]    s_axis_tdata,  // [63:0] argument
  input  wire logic [xrb_pkg::OP_W-1:0]      s_axis_tuser,  // [1:0] opcode
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [xrb_pkg::WORD_W-1:0]         m_axis_tdata,  // [63:0] value
  input  wire logic                          seed_we,
  input  wire logic [xrb_pkg::WORD_W-1:0]    seed_wdata
);

  xrb_pkg::dp_cmd_t  cmd;
  xrb_pkg::dp_stat_t stat;

  xrb_control u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .seed_we       (seed_we),
    .stat          (stat),
    .cmd           (cmd)
  );

  xrb_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tdata (s_axis_tdata),
    .seed_we      (seed_we),
    .seed_wdata   (seed_wdata),
    .cmd          (cmd),
    .stat         (stat),
    .value        (m_axis_tdata)
  );

endmodule

`default_nettype wire

### tb/tb_xoshiro256ss_bounded_random.sv
`default_nettype none

module tb_xoshiro256ss_bounded_random;

  localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] TOP_BIT    = 64'h8000_0000_0000_0000;
  localparam logic [63:0] SIZE_CASES = 64'd8;
  localparam int          HOLD_LEN   = 400;
  localparam int          PHASE_LEN  = 100;

  class rng_scoreboard;
    logic [63:0] gen_state [4];
    logic [63:0] expected_values [$];
    int          errors;
    int          n_checked;
    int          n_kind [4];

    function new();
      errors    = 0;
      n_checked = 0;
      foreach (n_kind[k]) n_kind[k] = 0;
      seed_words(64'd0);
    endfunction

    function logic [63:0] rotl(logic [63:0] v, int n);
      return (v << n) | (v >> (64 - n));
    endfunction

    // splitmix64 expansion of the seed into the four generator words
    function void seed_words(logic [63:0] s);
      logic [63:0] ctr;
      logic [63:0] z;
      ctr = s;
      for (int i = 0; i < 4; i++) begin
        ctr = ctr + xrb_pkg::GAMMA_STEP;
        z = ctr;
        z = (z ^ (z >> 30)) * xrb_pkg::MIX_MUL_A;
        z = (z ^ (z >> 27)) * xrb_pkg::MIX_MUL_B;
        gen_state[i] = z ^ (z >> 31);
      end
    endfunction

    function logic [63:0] next_raw();
      logic [63:0] result;
      logic [63:0] t;
      result = rotl(gen_state[1] * 64'd5, 7) * 64'd9;
      t = gen_state[1] << 17;
      gen_state[2] = gen_state[2] ^ gen_state[0];
      gen_state[3] = gen_state[3] ^ gen_state[1];
      gen_state[1] = gen_state[1] ^ gen_state[2];
      gen_state[0] = gen_state[0] ^ gen_state[3];
      gen_state[2] = gen_state[2] ^ t;
      gen_state[3] = rotl(gen_state[3], 45);
      return result;
    endfunction

    // unbiased draw below b by rejecting draws under (2^64 - b) mod b
    function logic [63:0] below(logic [63:0] b);
      logic [63:0] thr;
      logic [63:0] r;
      if (b <= 64'd1) return 64'd0;
      thr = (64'd0 - b) % b;
      do r = next_raw(); while (r < thr);
      return r % b;
    endfunction

    function logic [63:0] size_pick(logic [63:0] max_val);
      logic [63:0] c;
      logic [63:0] cap;
      c = below(SIZE_CASES);
      if (c == 64'd0) return 64'd0;
      if (c == 64'd1) return max_val;
      if (c <= 64'd4) begin
        cap = (max_val < xrb_pkg::SMALL_CAP) ? max_val : xrb_pkg::SMALL_CAP;
        return below(cap + 64'd1);
      end
      if (max_val == ALL_ONES) return next_raw();
      return below(max_val + 64'd1);
    endfunction

    function void note_request(xrb_pkg::op_t op, logic [63:0] arg);
      logic [63:0] v;
      case (op)
        xrb_pkg::OP_RAW:     v = next_raw();
        xrb_pkg::OP_BOUNDED: v = below(arg);
        xrb_pkg::OP_SIZE:    v = size_pick(arg);
        default:             v = 64'd0;
      endcase
      n_kind[op]++;
      expected_values = {expected_values, v};
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    task check_value(logic [63:0] got);
      logic [63:0] want;
      if (expected_values.size() == 0) begin
        report($sformatf("result beat %h with no request outstanding", got));
        return;
      end
      want = expected_values.pop_front();
      if (got !== want)
        report($sformatf("value %h, expected %h (result %0d)", got, want, n_checked));
      n_checked++;
    endtask

    function int pending();
      return expected_values.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        seed_we = 1'b0;
  logic [63:0] seed_wdata = '0;

  bit no_gaps  = 1'b0;
  bit hold_req = 1'b0;
  int seeds_loaded = 0;

  rng_scoreboard sb = new();

  xoshiro256ss_bounded_random uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .seed_we       (seed_we),
    .seed_wdata    (seed_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #6000000;
    $display("Timed out with %0d results outstanding", sb.pending());
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_value(m_axis_tdata);
  end

  // result side: random stalls per beat outside the no-gap stretch, plus one long hold-off
  initial begin : result_sink
    int wait_n;
    while (rst) @(posedge clk);
    forever begin
      wait_n = no_gaps ? 0 : $urandom_range(0, 18);
      if (hold_req) begin
        wait_n = wait_n + HOLD_LEN;
        hold_req = 1'b0;
      end
      if (wait_n != 0) begin
        m_axis_tready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // request beat; valid stays up across back-to-back beats
  task automatic send_request(input xrb_pkg::op_t op, input logic [63:0] arg);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {$urandom, $urandom};
      s_axis_tuser  <= 2'($urandom);
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= arg;
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(op, arg);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic load_seed(input logic [63:0] s);
    drain();
    seed_wdata <= s;
    seed_we    <= 1'b1;
    @(posedge clk);
    seed_we <= 1'b0;
    sb.seed_words(s);
    seeds_loaded++;
  endtask

  function automatic logic [63:0] pick_arg();
    int k;
    k = $urandom_range(0, 63);
    case ($urandom_range(0, 5))
      0:       return 64'($urandom_range(0, 20));
      1:       return {$urandom, $urandom};
      2:       return ALL_ONES - 64'($urandom_range(0, 3));
      3:       return (64'd1 << k) + 64'($urandom_range(0, 2)) - 64'd1;
      4:       return {32'd0, $urandom};
      default: return {$urandom, $urandom} >> k;
    endcase
  endfunction

  function automatic xrb_pkg::op_t pick_op();
    int r;
    r = $urandom_range(0, 19);
    if (r < 5)  return xrb_pkg::OP_RAW;
    if (r < 12) return xrb_pkg::OP_BOUNDED;
    if (r < 19) return xrb_pkg::OP_SIZE;
    return xrb_pkg::OP_NONE;
  endfunction

  initial begin : stimulus
    logic [63:0] phase_seeds [5];
    phase_seeds[0] = ALL_ONES;
    phase_seeds[1] = {$urandom, $urandom};
    phase_seeds[2] = 64'd0;
    phase_seeds[3] = TOP_BIT;
    phase_seeds[4] = {$urandom, $urandom};

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed beats on the reset seed
    send_request(xrb_pkg::OP_RAW, 64'd0);
    send_request(xrb_pkg::OP_RAW, ALL_ONES);
    send_request(xrb_pkg::OP_BOUNDED, 64'd0);
    send_request(xrb_pkg::OP_BOUNDED, 64'd1);
    send_request(xrb_pkg::OP_BOUNDED, 64'd2);
    send_request(xrb_pkg::OP_BOUNDED, 64'd3);
    send_request(xrb_pkg::OP_BOUNDED, 64'd16);
    send_request(xrb_pkg::OP_BOUNDED, ALL_ONES);
    send_request(xrb_pkg::OP_BOUNDED, TOP_BIT);
    send_request(xrb_pkg::OP_BOUNDED, TOP_BIT + 64'd1);  // rejects nearly half the draws
    send_request(xrb_pkg::OP_SIZE, 64'd0);
    send_request(xrb_pkg::OP_SIZE, 64'd1);
    send_request(xrb_pkg::OP_SIZE, 64'd15);
    send_request(xrb_pkg::OP_SIZE, 64'd16);
    send_request(xrb_pkg::OP_SIZE, 64'd17);
    send_request(xrb_pkg::OP_SIZE, ALL_ONES);
    send_request(xrb_pkg::OP_SIZE, ALL_ONES - 64'd1);
    send_request(xrb_pkg::OP_SIZE, TOP_BIT);
    send_request(xrb_pkg::OP_NONE, 64'h5A5A_A5A5_0F0F_F0F0);
    send_request(xrb_pkg::OP_NONE, ALL_ONES);
    send_request(xrb_pkg::OP_RAW, TOP_BIT);
    send_request(xrb_pkg::OP_SIZE, ALL_ONES);
    send_request(xrb_pkg::OP_SIZE, ALL_ONES);

    for (int p = 0; p < 5; p++) begin
      load_seed(phase_seeds[p]);
      for (int i = 0; i < PHASE_LEN; i++) begin
        no_gaps = (i >= 40 && i < 70);
        if (p == 1 && i == 20) hold_req = 1'b1;
        send_request(pick_op(), pick_arg());
      end
      no_gaps = 1'b0;
    end

    drain();
    repeat (200) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));

    $display("Checked %0d results over %0d seed loads", sb.n_checked, seeds_loaded + 1);
    $display("Requests: %0d raw, %0d bounded, %0d size, %0d unused opcode",
             sb.n_kind[xrb_pkg::OP_RAW], sb.n_kind[xrb_pkg::OP_BOUNDED],
             sb.n_kind[xrb_pkg::OP_SIZE], sb.n_kind[xrb_pkg::OP_NONE]);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
hdl/xrb_pkg.sv
hdl/xrb_divider.sv
hdl/xrb_datapath.sv
hdl/xrb_control.sv
hdl/xoshiro256ss_bounded_random.sv
tb/tb_xoshiro256ss_bounded_random.sv
